// ===== design/mm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, codes and helpers for the fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 8;

    localparam int unsigned SIZE_W  = 4;   // configuration register width
    localparam int unsigned IDX_W   = 3;   // row / column field width
    localparam int unsigned ELEM_W  = 16;  // Q8.8 element
    localparam int unsigned PROD_W  = 32;  // Q16.16 product
    localparam int unsigned ACC_W   = 36;  // Q20.16 sum
    localparam int unsigned CFG_A_W = 2;   // configuration index width

    typedef enum logic [1:0] {
        MODE_LOAD_LEFT  = 2'd0,
        MODE_LOAD_RIGHT = 2'd1,
        MODE_COMPUTE    = 2'd2,
        MODE_UNUSED     = 2'd3
    } mm_mode_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_RIGHT_COLS = 2'd2,
        CFG_NONE       = 2'd3
    } mm_cfg_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_ISSUE,
        MM_DRAIN
    } mm_state_t;

    // Tag that travels alongside each multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;   // first product of a dot product
        logic             fin;     // final product of a dot product
        logic             last;    // final element of the run
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mm_tag_t;

    // Clamp a size register to 1..max_dim and return size - 1.
    function automatic logic [SIZE_W-1:0] size_last(input logic [SIZE_W-1:0] v,
                                                    input int unsigned max_dim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (32'(v) > max_dim)
            r = SIZE_W'(max_dim - 1);
        else
            r = v - SIZE_W'(1);
        return r;
    endfunction

endpackage

// ===== design/matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply
// Fixed-point general matrix multiply: Q8.8 elements in, Q20.16 sums out.
// ----------------------------------------------------------------------------
// Load transactions (modes 0/1) leave the sequencer idle; busy stays low.
// Compute: one result per output element, once its inner_size products are
//   summed; busy drops once the MAC pipe has drained.
// Throughput is set by the single shared 16x16 multiplier: one MAC per cycle.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset (rst_n, async low) clears control and sizes to 3/2/3; stores undefined.
// ----------------------------------------------------------------------------
module matrix_multiply #(
    parameter int unsigned MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   mode,
    input  logic [mm_pkg::IDX_W-1:0]     row_index,
    input  logic [mm_pkg::IDX_W-1:0]     col_index,
    input  logic signed [mm_pkg::ELEM_W-1:0] element_value,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [mm_pkg::CFG_A_W-1:0]   cfg_index,
    input  logic [mm_pkg::SIZE_W-1:0]    cfg_data,
    // result channel
    output logic                         result_valid,
    output logic [mm_pkg::IDX_W-1:0]     result_row,
    output logic [mm_pkg::IDX_W-1:0]     result_col,
    output logic signed [mm_pkg::ACC_W-1:0] result_value,
    output logic                         last
);

    // Counter width covers 0..MAX_DIM-1; store address covers the full square.
    localparam int unsigned DW    = $clog2(MAX_DIM);
    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mm_pkg::SIZE_W-1:0] left_rows_reg, inner_size_reg, right_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_rows_reg  <= mm_pkg::SIZE_W'(3);
            inner_size_reg <= mm_pkg::SIZE_W'(2);
            right_cols_reg <= mm_pkg::SIZE_W'(3);
        end
        else if (cfg_write)
        begin
            unique case (mm_pkg::mm_cfg_t'(cfg_index))
                mm_pkg::CFG_LEFT_ROWS:  left_rows_reg  <= cfg_data;
                mm_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                mm_pkg::CFG_RIGHT_COLS: right_cols_reg <= cfg_data;
                default:                ;  // no such register
            endcase
        end
    end

    // Clamped sizes, held as size - 1 for terminal-count compares.
    logic [DW-1:0] nr_last, nk_last, nc_last;
    assign nr_last = DW'(mm_pkg::size_last(left_rows_reg,  MAX_DIM));
    assign nk_last = DW'(mm_pkg::size_last(inner_size_reg, MAX_DIM));
    assign nc_last = DW'(mm_pkg::size_last(right_cols_reg, MAX_DIM));

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    logic accept;
    logic in_range;
    logic wr_left, wr_right, go;
    logic [AW-1:0] wr_addr;

    assign accept   = start && !busy;
    assign in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
    assign wr_left  = accept && (mode == mm_pkg::MODE_LOAD_LEFT)  && in_range;
    assign wr_right = accept && (mode == mm_pkg::MODE_LOAD_RIGHT) && in_range;
    assign go       = accept && (mode == mm_pkg::MODE_COMPUTE);
    assign wr_addr  = AW'(32'(row_index) * MAX_DIM + 32'(col_index));

    // ------------------------------------------------------------------
    // Sequencer: walks r, c, k and issues one MAC per cycle
    // ------------------------------------------------------------------
    mm_pkg::mm_state_t state_reg, state_next;
    logic [DW-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    mm_pkg::mm_tag_t issue_tag;
    logic [AW-1:0] rd_addr_a, rd_addr_b;

    mm_pkg::mm_tag_t tag1_reg, tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::MM_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        issue_tag  = '0;

        unique case (state_reg)
            mm_pkg::MM_IDLE:
            begin
                if (go)
                begin
                    state_next = mm_pkg::MM_ISSUE;
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                end
            end
            mm_pkg::MM_ISSUE:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (k_reg == '0);
                issue_tag.fin   = (k_reg == nk_last);
                issue_tag.last  = (k_reg == nk_last) && (c_reg == nc_last)
                                  && (r_reg == nr_last);
                issue_tag.row   = mm_pkg::IDX_W'(r_reg);
                issue_tag.col   = mm_pkg::IDX_W'(c_reg);
                if (k_reg == nk_last)
                begin
                    k_next = '0;
                    if (c_reg == nc_last)
                    begin
                        c_next = '0;
                        if (r_reg == nr_last)
                            state_next = mm_pkg::MM_DRAIN;
                        else
                            r_next = r_reg + DW'(1);
                    end
                    else
                        c_next = c_reg + DW'(1);
                end
                else
                    k_next = k_reg + DW'(1);
            end
            mm_pkg::MM_DRAIN:
            begin
                // wait for the MAC pipe to empty
                if (!tag1_reg.valid && !tag2_reg.valid)
                    state_next = mm_pkg::MM_IDLE;
            end
            default:
                state_next = mm_pkg::MM_IDLE;
        endcase
    end

    assign busy      = (state_reg != mm_pkg::MM_IDLE);
    assign rd_addr_a = AW'(32'(r_reg) * MAX_DIM + 32'(k_reg));   // A[r][k]
    assign rd_addr_b = AW'(32'(k_reg) * MAX_DIM + 32'(c_reg));   // B[k][c]

    // ------------------------------------------------------------------
    // Element stores: one write port, one registered read port each
    // ------------------------------------------------------------------
    logic [mm_pkg::ELEM_W-1:0] left_mem  [DEPTH];
    logic [mm_pkg::ELEM_W-1:0] right_mem [DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] left_q_reg, right_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_left)
            left_mem[wr_addr] <= element_value;
        left_q_reg <= left_mem[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (wr_right)
            right_mem[wr_addr] <= element_value;
        right_q_reg <= right_mem[rd_addr_b];
    end

    // ------------------------------------------------------------------
    // MAC pipe: read -> multiply -> accumulate / emit
    // ------------------------------------------------------------------
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_reg, acc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
        end
    end

    // Q8.8 x Q8.8 -> exact Q16.16
    always_ff @(posedge clk)
    begin
        prod_reg <= left_q_reg * right_q_reg;
    end

    assign acc_sum = (tag2_reg.first ? '0 : acc_reg) + mm_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (tag2_reg.valid)
            acc_reg <= acc_sum;
    end

    // Result register: strobe resets, payload does not.
    logic result_valid_reg;
    logic [mm_pkg::IDX_W-1:0] result_row_reg, result_col_reg;
    logic signed [mm_pkg::ACC_W-1:0] result_value_reg;
    logic result_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= tag2_reg.valid && tag2_reg.fin;
    end

    always_ff @(posedge clk)
    begin
        if (tag2_reg.valid && tag2_reg.fin)
        begin
            result_row_reg   <= tag2_reg.row;
            result_col_reg   <= tag2_reg.col;
            result_value_reg <= acc_sum;
            result_last_reg  <= tag2_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_row   = result_row_reg;
    assign result_col   = result_col_reg;
    assign result_value = result_value_reg;
    assign last         = result_valid_reg && result_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a compute transaction always makes the block busy next cycle
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> busy)
        else $error("compute accepted but block not busy");

    // results only come out of a run
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe outside a compute run");

    // the MAC pipe only holds work while the sequencer is out of idle
    a_pipe_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (tag1_reg.valid || tag2_reg.valid) |-> (state_reg != mm_pkg::MM_IDLE))
        else $error("MAC pipe busy with sequencer idle");

    // nothing follows the final element of a run straight away
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result after final element");
`endif

endmodule
